@@ sv/fat16_geometry_chain_allocator_top_assert.svh @@
// Assertion macros shared by the allocator RTL.
`ifndef FAT16_GEOMETRY_CHAIN_ALLOCATOR_TOP_ASSERT_SVH
`define FAT16_GEOMETRY_CHAIN_ALLOCATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// expression must hold at every edge outside reset
`define F16CA_ASSERT_HOLDS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("f16ca: invariant violated");
// consequent must hold in the cycle after the antecedent
`define F16CA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("f16ca: sequence violated");
`else
`define F16CA_ASSERT_HOLDS(label, clk, rst, expr)
`define F16CA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ sv/f16ca_pkg.sv @@
// Types, codes and volume layout constants of the FAT16 allocator.
package f16ca_pkg;

   typedef enum logic [1:0] {
      CMD_FORMAT = 2'd0,
      CMD_ALLOC  = 2'd1,
      CMD_QUERY  = 2'd2,
      CMD_NONE   = 2'd3
   } command_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_SMALL    = 3'd1,
      ST_FATBIG   = 3'd2,
      ST_BAND     = 3'd3,
      ST_FULL     = 3'd4,
      ST_CHAINS   = 3'd5,
      ST_NOTREADY = 3'd6
   } status_type;

   // layout of the volume
   localparam logic [31:0] RESERVED_SECTORS     = 32'd1;
   localparam logic [31:0] FAT_COPIES           = 32'd2;
   localparam logic [31:0] ROOT_DIR_SECTORS     = 32'd32;
   localparam logic [8:0]  MAX_FAT_SECTORS      = 9'd256;
   // sectors per cluster is 1 << SPC_SHIFT
   localparam int          SPC_SHIFT            = 0;

   localparam logic [31:0] MIN_VOLUME_SECTORS   = 32'd4096;
   localparam logic [31:0] FAT16_MIN_CLUSTERS   = 32'd4085;
   localparam logic [31:0] FAT16_LIMIT_CLUSTERS = 32'd65525;
   localparam logic [15:0] ENTRY_MEDIA          = 16'hFFF8;
   localparam logic [15:0] ENTRY_END            = 16'hFFFF;
   localparam logic [16:0] FIRST_CLUSTER        = 17'd2;

   // controller to datapath
   typedef struct packed {
      logic       load;
      logic       fmt_init;
      logic       fmt_calc;
      logic       fmt_step;
      logic       fmt_commit;
      logic       set_st;
      status_type st;
      logic       alloc;
      logic       query_special;
      logic       scan_start;
      logic       scan_next;
      logic       query_hit;
      logic       out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      command_type command;
      logic        small_vol;
      logic        need_le;
      logic        need_big;
      logic        band_bad;
      logic        query_special;
      logic        scan_empty;
      logic        scan_hit;
      logic        scan_end;
   } stat_type;

endpackage

@@ sv/f16ca_if.sv @@
// Request and response channel interfaces of the FAT16 allocator.
interface f16ca_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [31:0] volume_sectors;
   logic [15:0] chain_length;
   logic [15:0] cluster_index;

   modport source (output valid, command, volume_sectors, chain_length, cluster_index,
                   input ready);
   modport sink (input valid, command, volume_sectors, chain_length, cluster_index,
                 output ready);
endinterface

interface f16ca_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [8:0]  fat_size;
   logic [15:0] cluster_total;
   logic [10:0] data_start;
   logic [15:0] chain_start;
   logic [15:0] fat_entry;

   modport source (output valid, status, fat_size, cluster_total, data_start,
                   chain_start, fat_entry, input ready);
   modport sink (input valid, status, fat_size, cluster_total, data_start,
                 chain_start, fat_entry, output ready);
endinterface

@@ sv/f16ca_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module f16ca_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/f16ca_ctrl.sv @@
// Sequencing state machine of the FAT16 allocator.
`include "fat16_geometry_chain_allocator_top_assert.svh"
module f16ca_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  f16ca_pkg::stat_type dp_stat,
   output f16ca_pkg::cmd_type  dp_cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_FMT_CALC,
      S_FMT_CHECK,
      S_QUERY_SCAN,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      dp_cmd       = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               dp_cmd.load = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (dp_stat.command)
               f16ca_pkg::CMD_FORMAT: begin
                  dp_cmd.fmt_init = 1'b1;
                  if (dp_stat.small_vol) begin
                     dp_cmd.set_st = 1'b1;
                     dp_cmd.st     = f16ca_pkg::ST_SMALL;
                     state_in      = S_FINISH;
                  end else begin
                     state_in = S_FMT_CALC;
                  end
               end
               f16ca_pkg::CMD_ALLOC: begin
                  dp_cmd.alloc = 1'b1;
                  state_in     = S_FINISH;
               end
               f16ca_pkg::CMD_QUERY: begin
                  priority if (dp_stat.query_special) begin
                     dp_cmd.query_special = 1'b1;
                     state_in             = S_FINISH;
                  end else if (dp_stat.scan_empty) begin
                     state_in = S_FINISH;
                  end else begin
                     dp_cmd.scan_start = 1'b1;
                     state_in          = S_QUERY_SCAN;
                  end
               end
               f16ca_pkg::CMD_NONE: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_FMT_CALC: begin
            dp_cmd.fmt_calc = 1'b1;
            state_in        = S_FMT_CHECK;
         end
         S_FMT_CHECK: begin
            priority if (dp_stat.need_le) begin
               if (dp_stat.band_bad) begin
                  dp_cmd.set_st = 1'b1;
                  dp_cmd.st     = f16ca_pkg::ST_BAND;
               end else begin
                  dp_cmd.fmt_commit = 1'b1;
               end
               state_in = S_FINISH;
            end else if (dp_stat.need_big) begin
               dp_cmd.set_st = 1'b1;
               dp_cmd.st     = f16ca_pkg::ST_FATBIG;
               state_in      = S_FINISH;
            end else begin
               dp_cmd.fmt_step = 1'b1;
               state_in        = S_FMT_CALC;
            end
         end
         S_QUERY_SCAN: begin
            priority if (dp_stat.scan_hit) begin
               dp_cmd.query_hit = 1'b1;
               state_in         = S_FINISH;
            end else if (dp_stat.scan_end) begin
               state_in = S_FINISH;
            end else begin
               dp_cmd.scan_next = 1'b1;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               dp_cmd.out_load = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // a finished word goes out and the controller is free again
   `F16CA_ASSERT_NEXT(a_finish_delivers, clock, reset,
                      state_ff == S_FINISH && out_free,
                      state_ff == S_IDLE && rsp_valid_ff)
   // never overwrite a word still waiting on the response side
   `F16CA_ASSERT_HOLDS(a_no_overwrite, clock, reset,
                       !(dp_cmd.out_load && rsp_valid_ff && !rsp_ready))

endmodule

@@ sv/f16ca_dp.sv @@
// Datapath of the FAT16 allocator: geometry solver, chain table and result word.
`include "fat16_geometry_chain_allocator_top_assert.svh"
module f16ca_dp #(
   parameter int MAX_CHAINS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  f16ca_pkg::cmd_type  dp_cmd,
   output f16ca_pkg::stat_type dp_stat,
   input  logic [1:0]          req_command,
   input  logic [31:0]         req_volume_sectors,
   input  logic [15:0]         req_chain_length,
   input  logic [15:0]         req_cluster_index,
   output logic [2:0]          rsp_status,
   output logic [8:0]          rsp_fat_size,
   output logic [15:0]         rsp_cluster_total,
   output logic [10:0]         rsp_data_start,
   output logic [15:0]         rsp_chain_start,
   output logic [15:0]         rsp_fat_entry
);

   localparam int AW = (MAX_CHAINS > 1) ? $clog2(MAX_CHAINS) : 1;
   localparam int CW = $clog2(MAX_CHAINS + 1);

   // captured request
   f16ca_pkg::command_type command_ff;
   logic [31:0] sectors_ff;
   logic [15:0] length_ff;
   logic [15:0] cindex_ff;

   // volume state
   logic          vol_valid_ff;
   logic [15:0]   cluster_count_ff;
   logic [16:0]   next_free_ff;
   logic [CW-1:0] chain_count_ff;

   // geometry iteration
   logic [8:0]  fsz_ff;
   logic [31:0] cl_ff;
   logic [31:0] overhead;
   logic [31:0] data_sec;
   logic [32:0] need;

   // query scan
   logic [CW-1:0] addr_ff;
   logic          chk_vld_ff;
   logic          chk_last_ff;
   logic [31:0]   rd_data;
   logic [16:0]   chain_end;
   logic [16:0]   cindex_next;
   logic          match;
   logic [15:0]   hit_entry;

   // allocate
   logic [16:0]            alloc_len;
   logic                   alloc_full;
   logic                   alloc_ok;
   f16ca_pkg::status_type  alloc_st;

   // result being built, and the output word
   f16ca_pkg::status_type res_status_ff, out_status_ff;
   logic [8:0]  res_fat_ff,   out_fat_ff;
   logic [15:0] res_cl_ff,    out_cl_ff;
   logic [10:0] res_ds_ff,    out_ds_ff;
   logic [15:0] res_cs_ff,    out_cs_ff;
   logic [15:0] res_ent_ff,   out_ent_ff;

   // one round of the FAT size fixed point
   assign overhead = f16ca_pkg::RESERVED_SECTORS + f16ca_pkg::FAT_COPIES * 32'(fsz_ff)
                   + f16ca_pkg::ROOT_DIR_SECTORS;
   assign data_sec = (sectors_ff > overhead) ? (sectors_ff - overhead) : 32'd0;
   // ceil((cl + 2) * 2 / 512)
   assign need     = (33'(cl_ff) + 33'd257) >> 8;

   assign alloc_len  = (length_ff == 16'd0) ? 17'd1 : 17'(length_ff);
   assign alloc_full = (18'(next_free_ff) + 18'(alloc_len)) > (18'(cluster_count_ff) + 18'd2);

   always_comb begin
      alloc_ok = 1'b0;
      priority if (!vol_valid_ff) begin
         alloc_st = f16ca_pkg::ST_NOTREADY;
      end else if (alloc_full) begin
         alloc_st = f16ca_pkg::ST_FULL;
      end else if (chain_count_ff >= CW'(MAX_CHAINS)) begin
         alloc_st = f16ca_pkg::ST_CHAINS;
      end else begin
         alloc_st = f16ca_pkg::ST_OK;
         alloc_ok = dp_cmd.alloc;
      end
   end

   f16ca_ram #(
      .WIDTH(32),
      .DEPTH(MAX_CHAINS)
   ) u_chain_ram (
      .clock  (clock),
      .wr_en  (alloc_ok),
      .wr_addr(chain_count_ff[AW-1:0]),
      .wr_data({next_free_ff[15:0], alloc_len[15:0]}),
      .rd_addr(addr_ff[AW-1:0]),
      .rd_data(rd_data)
   );

   // table word: first cluster in the upper half, length in the lower
   assign chain_end   = 17'(rd_data[31:16]) + 17'(rd_data[15:0]);
   assign cindex_next = 17'(cindex_ff) + 17'd1;
   assign match       = chk_vld_ff && (cindex_ff >= rd_data[31:16])
                        && (17'(cindex_ff) < chain_end);
   assign hit_entry   = (cindex_next < chain_end) ? cindex_next[15:0] : f16ca_pkg::ENTRY_END;

   assign dp_stat.command       = command_ff;
   assign dp_stat.small_vol     = sectors_ff < f16ca_pkg::MIN_VOLUME_SECTORS;
   assign dp_stat.need_le       = need <= 33'(fsz_ff);
   assign dp_stat.need_big      = need > 33'(f16ca_pkg::MAX_FAT_SECTORS);
   assign dp_stat.band_bad      = (cl_ff < f16ca_pkg::FAT16_MIN_CLUSTERS)
                                  || (cl_ff >= f16ca_pkg::FAT16_LIMIT_CLUSTERS);
   assign dp_stat.query_special = cindex_ff < 16'd2;
   assign dp_stat.scan_empty    = chain_count_ff == '0;
   assign dp_stat.scan_hit      = match;
   assign dp_stat.scan_end      = chk_vld_ff && chk_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vol_valid_ff     <= 1'b0;
         cluster_count_ff <= '0;
         next_free_ff     <= f16ca_pkg::FIRST_CLUSTER;
         chain_count_ff   <= '0;
         chk_vld_ff       <= 1'b0;
      end else begin
         if (dp_cmd.fmt_init) begin
            vol_valid_ff <= 1'b0;
         end
         if (dp_cmd.fmt_commit) begin
            vol_valid_ff     <= 1'b1;
            cluster_count_ff <= cl_ff[15:0];
            next_free_ff     <= f16ca_pkg::FIRST_CLUSTER;
            chain_count_ff   <= '0;
         end
         if (alloc_ok) begin
            chain_count_ff <= chain_count_ff + CW'(1);
            next_free_ff   <= next_free_ff + alloc_len;
         end
         if (dp_cmd.scan_start) begin
            chk_vld_ff <= 1'b0;
         end else if (dp_cmd.scan_next) begin
            chk_vld_ff <= addr_ff < chain_count_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         command_ff    <= f16ca_pkg::command_type'(req_command);
         sectors_ff    <= req_volume_sectors;
         length_ff     <= req_chain_length;
         cindex_ff     <= req_cluster_index;
         res_status_ff <= f16ca_pkg::ST_OK;
         res_fat_ff    <= '0;
         res_cl_ff     <= '0;
         res_ds_ff     <= '0;
         res_cs_ff     <= '0;
         res_ent_ff    <= '0;
      end
      if (dp_cmd.fmt_init) begin
         fsz_ff <= 9'd1;
      end
      if (dp_cmd.fmt_calc) begin
         cl_ff <= data_sec >> f16ca_pkg::SPC_SHIFT;
      end
      if (dp_cmd.fmt_step) begin
         fsz_ff <= need[8:0];
      end
      if (dp_cmd.set_st) begin
         res_status_ff <= dp_cmd.st;
      end
      if (dp_cmd.fmt_commit) begin
         res_fat_ff <= fsz_ff;
         res_cl_ff  <= cl_ff[15:0];
         res_ds_ff  <= overhead[10:0];
      end
      if (dp_cmd.alloc) begin
         res_status_ff <= alloc_st;
      end
      if (alloc_ok) begin
         res_cs_ff <= next_free_ff[15:0];
      end
      if (dp_cmd.query_special) begin
         res_ent_ff <= (cindex_ff == 16'd0) ? f16ca_pkg::ENTRY_MEDIA : f16ca_pkg::ENTRY_END;
      end
      if (dp_cmd.scan_start) begin
         addr_ff <= '0;
      end else if (dp_cmd.scan_next) begin
         addr_ff     <= addr_ff + CW'(1);
         chk_last_ff <= addr_ff == (chain_count_ff - CW'(1));
      end
      if (dp_cmd.query_hit) begin
         res_ent_ff <= hit_entry;
      end
      if (dp_cmd.out_load) begin
         out_status_ff <= res_status_ff;
         out_fat_ff    <= res_fat_ff;
         out_cl_ff     <= res_cl_ff;
         out_ds_ff     <= res_ds_ff;
         out_cs_ff     <= res_cs_ff;
         out_ent_ff    <= res_ent_ff;
      end
   end

   assign rsp_status        = out_status_ff;
   assign rsp_fat_size      = out_fat_ff;
   assign rsp_cluster_total = out_cl_ff;
   assign rsp_data_start    = out_ds_ff;
   assign rsp_chain_start   = out_cs_ff;
   assign rsp_fat_entry     = out_ent_ff;

   `F16CA_ASSERT_HOLDS(a_chain_count_max, clock, reset, chain_count_ff <= CW'(MAX_CHAINS))
   // allocation never runs past the end of the data area
   `F16CA_ASSERT_HOLDS(a_free_in_volume, clock, reset,
                       18'(next_free_ff) <= 18'(cluster_count_ff) + 18'd2)
   // each extra round grows the FAT and stays within the limit
   `F16CA_ASSERT_NEXT(a_fat_grows, clock, reset, dp_cmd.fmt_step,
                      fsz_ff > $past(fsz_ff) && fsz_ff <= f16ca_pkg::MAX_FAT_SECTORS)

endmodule

@@ sv/fat16_geometry_chain_allocator_top.sv @@
// From accept to response valid, allocate, special query, empty table, small volume and idle
// command pass through decode and finish; format takes up to two fixed-point rounds, each a
// calc and a check state; a chain query reads one chain table word per cycle from the RAM.
// The next request is taken as soon as the result enters the output register, even while
// that word waits for rsp ready.
// Reset clears the volume state; the chain table RAM is not cleared and needs no pass.
module fat16_geometry_chain_allocator_top #(
   parameter int MAX_CHAINS = 32
) (
   input logic           clock,
   input logic           reset,
   f16ca_req_if.sink     req_ch,
   f16ca_rsp_if.source   rsp_ch
);

   f16ca_pkg::cmd_type  dp_cmd;
   f16ca_pkg::stat_type dp_stat;

   f16ca_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .rsp_valid(rsp_ch.valid),
      .rsp_ready(rsp_ch.ready),
      .dp_stat  (dp_stat),
      .dp_cmd   (dp_cmd)
   );

   f16ca_dp #(
      .MAX_CHAINS(MAX_CHAINS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .dp_cmd            (dp_cmd),
      .dp_stat           (dp_stat),
      .req_command       (req_ch.command),
      .req_volume_sectors(req_ch.volume_sectors),
      .req_chain_length  (req_ch.chain_length),
      .req_cluster_index (req_ch.cluster_index),
      .rsp_status        (rsp_ch.status),
      .rsp_fat_size      (rsp_ch.fat_size),
      .rsp_cluster_total (rsp_ch.cluster_total),
      .rsp_data_start    (rsp_ch.data_start),
      .rsp_chain_start   (rsp_ch.chain_start),
      .rsp_fat_entry     (rsp_ch.fat_entry)
   );

endmodule
